// ===== rtl/sjis_xl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_xl_pkg
// Shared types, codes and constants of the code translator pipeline.
// ----------------------------------------------------------------------------
package sjis_xl_pkg;

	localparam int CODE_W    = 16;
	localparam int IDX_W     = 14;
	localparam int LAST_W    = 7;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam int RANGE_DEPTH_DEF   = 128;
	localparam int UNICODE_DEPTH_DEF = 8192;
	localparam int CUSTOM_DEPTH_DEF  = 16384;

	localparam logic [LAST_W-1:0] RESET_LAST_ENTRY  = 7'h5A;
	localparam logic [CODE_W-1:0] RESET_CUSTOM_LOW  = 16'hA600;
	localparam logic [CODE_W-1:0] RESET_CUSTOM_HIGH = 16'hDDFF;
	localparam logic [CODE_W-1:0] NOT_FOUND_CHAR    = 16'h003F;

	typedef enum logic [1:0] {
		MODE_XLAT     = 2'd0,
		MODE_LD_RANGE = 2'd1,
		MODE_LD_UNI   = 2'd2,
		MODE_LD_CUST  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_RANGE    = 2'd0,
		ST_CUSTOM   = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LAST_ENTRY  = 2'd0,
		CFG_CUSTOM_LOW  = 2'd1,
		CFG_CUSTOM_HIGH = 2'd2
	} cfg_reg_t;

	// One item as it travels down the pipeline.
	typedef struct packed {
		logic              vld;
		mode_t             mode;
		logic [CODE_W-1:0] code;
		logic [IDX_W-1:0]  lidx;
		logic [CODE_W-1:0] lval;
		logic [CODE_W-1:0] loff;
		logic              win;
		logic [CODE_W-1:0] cidx;
	} item_t;

	// Search progress of one item.
	typedef struct packed {
		logic              act;
		logic              found;
		logic [CODE_W-1:0] bound;
	} srch_t;

endpackage
`default_nettype wire

// ===== rtl/sjis_custom_to_utf16_translator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_custom_to_utf16_translator_top
// Pipeline: one entry stage, two stages per search probe and four tail stages.
// Throughput: one item per cycle while out_stall is low.
// Every probe owns its bound table copy.
// Reset: pipeline empties and config returns to its defaults; tables keep
//   their contents and need no clearing pass.
// ----------------------------------------------------------------------------
module sjis_custom_to_utf16_translator_top #(
	parameter int RANGE_DEPTH   = sjis_xl_pkg::RANGE_DEPTH_DEF,
	parameter int UNICODE_DEPTH = sjis_xl_pkg::UNICODE_DEPTH_DEF,
	parameter int CUSTOM_DEPTH  = sjis_xl_pkg::CUSTOM_DEPTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration write port
	input  wire                                 cfg_we,
	input  wire  [sjis_xl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [sjis_xl_pkg::CFG_W-1:0]       cfg_data,
	// input item channel
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  [1:0]                          mode,
	input  wire  [sjis_xl_pkg::CODE_W-1:0]      code,
	input  wire  [sjis_xl_pkg::IDX_W-1:0]       load_index,
	input  wire  [sjis_xl_pkg::CODE_W-1:0]      load_value,
	input  wire  [sjis_xl_pkg::CODE_W-1:0]      load_offset,
	// result item channel
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [sjis_xl_pkg::CODE_W-1:0]      char_out,
	output logic [1:0]                          status
);

	localparam int RW     = $clog2(RANGE_DEPTH);
	// Worst-case number of probes over RANGE_DEPTH entries.
	localparam int LEVELS = $clog2(RANGE_DEPTH + 1);

	// Configuration registers.
	logic [sjis_xl_pkg::LAST_W-1:0] last_q;
	logic [sjis_xl_pkg::CODE_W-1:0] clow_q, chigh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= sjis_xl_pkg::RESET_LAST_ENTRY;
			clow_q  <= sjis_xl_pkg::RESET_CUSTOM_LOW;
			chigh_q <= sjis_xl_pkg::RESET_CUSTOM_HIGH;
		end else if (cfg_we) begin
			case (sjis_xl_pkg::cfg_reg_t'(cfg_index))
				sjis_xl_pkg::CFG_LAST_ENTRY:  last_q  <= cfg_data[sjis_xl_pkg::LAST_W-1:0];
				sjis_xl_pkg::CFG_CUSTOM_LOW:  clow_q  <= cfg_data;
				sjis_xl_pkg::CFG_CUSTOM_HIGH: chigh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Entry stage: window test, custom index and the initial search limits.
	sjis_xl_pkg::item_t in_item, item_s1;
	sjis_xl_pkg::srch_t in_srch, srch_s1;
	logic [RW-1:0] hi_init, hi_s1;
	logic en_s1;

	// Per-boundary links; entry l feeds probe l, the last one feeds the tail.
	sjis_xl_pkg::item_t lv_item [LEVELS+1];
	sjis_xl_pkg::srch_t lv_srch [LEVELS+1];
	logic [RW-1:0]      lv_lo   [LEVELS+1];
	logic [RW-1:0]      lv_hi   [LEVELS+1];
	logic               lv_rdy  [LEVELS+1];

	always_comb begin
		in_item.vld  = in_valid;
		in_item.mode = sjis_xl_pkg::mode_t'(mode);
		in_item.code = code;
		in_item.lidx = load_index;
		in_item.lval = load_value;
		in_item.loff = load_offset;
		// an empty window (low above high) matches nothing
		in_item.win  = (code >= clow_q) && (code <= chigh_q);
		in_item.cidx = code - clow_q;

		// search only translations outside the custom window
		in_srch.act   = (in_item.mode == sjis_xl_pkg::MODE_XLAT) && !in_item.win;
		in_srch.found = 1'b0;
		in_srch.bound = '0;

		// clamp the last searched entry to the table depth
		if (32'(last_q) > 32'(RANGE_DEPTH - 1)) begin
			hi_init = RW'(RANGE_DEPTH - 1);
		end else begin
			hi_init = RW'(last_q);
		end
	end

	// Advance the entry stage whenever it is empty or the first probe takes its item.
	assign en_s1    = !item_s1.vld || lv_rdy[0];
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
			srch_s1 <= '0;
			hi_s1   <= '0;
		end else if (en_s1) begin
			item_s1 <= in_item;
			srch_s1 <= in_srch;
			hi_s1   <= hi_init;
		end
	end

	assign lv_item[0] = item_s1;
	assign lv_srch[0] = srch_s1;
	assign lv_lo[0]   = '0;
	assign lv_hi[0]   = hi_s1;

	// Binary search: one probe module per halving step.
	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		sjis_xl_srch_lvl #(
			.RANGE_DEPTH (RANGE_DEPTH)
		) u_lvl (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_item (lv_item[l]),
			.up_srch (lv_srch[l]),
			.up_lo   (lv_lo[l]),
			.up_hi   (lv_hi[l]),
			.up_rdy  (lv_rdy[l]),
			.dn_item (lv_item[l+1]),
			.dn_srch (lv_srch[l+1]),
			.dn_lo   (lv_lo[l+1]),
			.dn_hi   (lv_hi[l+1]),
			.dn_rdy  (lv_rdy[l+1])
		);
	end

	// Offset lookup, table index, table reads and output register.
	// The hit entry index rides in the lo field after the search.
	sjis_xl_tail #(
		.RANGE_DEPTH   (RANGE_DEPTH),
		.UNICODE_DEPTH (UNICODE_DEPTH),
		.CUSTOM_DEPTH  (CUSTOM_DEPTH)
	) u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_item   (lv_item[LEVELS]),
		.up_srch   (lv_srch[LEVELS]),
		.up_ent    (lv_lo[LEVELS]),
		.up_rdy    (lv_rdy[LEVELS]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_out  (char_out),
		.status    (status)
	);

endmodule
`default_nettype wire

// ===== rtl/sjis_xl_srch_lvl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_xl_srch_lvl
// One probe of the binary range search: bound read, then compare and narrow.
// Holds its own copy of the bound table, written by range loads in order.
// ----------------------------------------------------------------------------
module sjis_xl_srch_lvl #(
	parameter int  RANGE_DEPTH = sjis_xl_pkg::RANGE_DEPTH_DEF,
	localparam int RW          = $clog2(RANGE_DEPTH)
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  sjis_xl_pkg::item_t       up_item,
	input  sjis_xl_pkg::srch_t       up_srch,
	input  wire  [RW-1:0]            up_lo,
	input  wire  [RW-1:0]            up_hi,
	output logic                     up_rdy,
	output sjis_xl_pkg::item_t       dn_item,
	output sjis_xl_pkg::srch_t       dn_srch,
	output logic [RW-1:0]            dn_lo,
	output logic [RW-1:0]            dn_hi,
	input  wire                      dn_rdy
);

	logic [sjis_xl_pkg::CODE_W-1:0] bnd_mem [RANGE_DEPTH];

	sjis_xl_pkg::item_t item_s1, item_s2, item_nx;
	sjis_xl_pkg::srch_t srch_s1, srch_s2, srch_nx;
	logic [RW-1:0] lo_s1, hi_s1, mid_s1, lo_s2, hi_s2, lo_nx, hi_nx;
	logic [sjis_xl_pkg::CODE_W-1:0] here_s1, next_s1;
	logic [RW:0]   sum;
	logic [RW-1:0] mid, mid_nx;
	logic en_s1, en_s2, ld_ok, ge, lt, at_hi;

	assign en_s2  = !item_s2.vld || dn_rdy;
	assign en_s1  = !item_s1.vld || en_s2;
	assign up_rdy = en_s1;

	assign sum    = {1'b0, up_lo} + {1'b0, up_hi};
	assign mid    = sum[RW:1];
	assign mid_nx = mid + RW'(1);
	assign ld_ok  = 32'(up_item.lidx) < 32'(RANGE_DEPTH);

	// Bound copy: write on range load, read probe entry and its successor.
	always_ff @(posedge clk) begin
		if (en_s1 && up_item.vld && up_item.mode == sjis_xl_pkg::MODE_LD_RANGE && ld_ok) begin
			bnd_mem[RW'(up_item.lidx)] <= up_item.lval;
		end
		if (en_s1) begin
			here_s1 <= bnd_mem[mid];
			next_s1 <= bnd_mem[mid_nx];
		end
	end

	assign ge    = item_s1.code >= here_s1;
	assign lt    = item_s1.code < next_s1;
	assign at_hi = mid_s1 == hi_s1;

	always_comb begin
		item_nx = item_s1;
		srch_nx = srch_s1;
		lo_nx   = lo_s1;
		hi_nx   = hi_s1;
		if (srch_s1.act) begin
			if (ge && (at_hi || lt)) begin
				// hit: park the entry index in lo
				srch_nx.act   = 1'b0;
				srch_nx.found = 1'b1;
				srch_nx.bound = here_s1;
				lo_nx         = mid_s1;
			end else if (here_s1 < item_s1.code) begin
				if (at_hi) begin
					srch_nx.act = 1'b0;
				end else begin
					lo_nx = mid_s1 + RW'(1);
				end
			end else begin
				if (mid_s1 == lo_s1) begin
					srch_nx.act = 1'b0;
				end else begin
					hi_nx = mid_s1 - RW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
			srch_s1 <= '0;
			lo_s1   <= '0;
			hi_s1   <= '0;
			mid_s1  <= '0;
			item_s2 <= '0;
			srch_s2 <= '0;
			lo_s2   <= '0;
			hi_s2   <= '0;
		end else begin
			if (en_s1) begin
				item_s1 <= up_item;
				srch_s1 <= up_srch;
				lo_s1   <= up_lo;
				hi_s1   <= up_hi;
				mid_s1  <= mid;
			end
			if (en_s2) begin
				item_s2 <= item_nx;
				srch_s2 <= srch_nx;
				lo_s2   <= lo_nx;
				hi_s2   <= hi_nx;
			end
		end
	end

	assign dn_item = item_s2;
	assign dn_srch = srch_s2;
	assign dn_lo   = lo_s2;
	assign dn_hi   = hi_s2;

endmodule
`default_nettype wire

// ===== rtl/sjis_xl_tail.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_xl_tail
// Offset read, table index and status, UTF-16 and custom table reads, and
// the output register. Loads of the three tables are applied here in order.
// ----------------------------------------------------------------------------
module sjis_xl_tail #(
	parameter int  RANGE_DEPTH   = sjis_xl_pkg::RANGE_DEPTH_DEF,
	parameter int  UNICODE_DEPTH = sjis_xl_pkg::UNICODE_DEPTH_DEF,
	parameter int  CUSTOM_DEPTH  = sjis_xl_pkg::CUSTOM_DEPTH_DEF,
	localparam int RW            = $clog2(RANGE_DEPTH),
	localparam int UA            = $clog2(UNICODE_DEPTH),
	localparam int CA            = $clog2(CUSTOM_DEPTH)
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  sjis_xl_pkg::item_t               up_item,
	input  sjis_xl_pkg::srch_t               up_srch,
	input  wire  [RW-1:0]                    up_ent,
	output logic                             up_rdy,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [sjis_xl_pkg::CODE_W-1:0]   char_out,
	output logic [1:0]                       status
);

	logic [sjis_xl_pkg::CODE_W-1:0] off_mem [RANGE_DEPTH];
	logic [sjis_xl_pkg::CODE_W-1:0] uni_mem [UNICODE_DEPTH];
	logic [sjis_xl_pkg::CODE_W-1:0] cus_mem [CUSTOM_DEPTH];

	sjis_xl_pkg::item_t   item_s1, item_s2, item_s3;
	sjis_xl_pkg::srch_t   srch_s1;
	sjis_xl_pkg::status_t st_nx, st_s2, st_s3, st_s4;
	logic [sjis_xl_pkg::CODE_W-1:0] off_s1, uni_rd_s3, cus_rd_s3, char_nx, char_s4;
	logic [sjis_xl_pkg::CODE_W:0]   uidx;
	logic [UA-1:0] uaddr_s2;
	logic vld_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	logic ld_off_ok, ld_uni_ok, ld_cus_ok, uni_ok, cus_ok;

	assign en_s4  = !vld_s4 || !out_stall;
	assign en_s3  = !item_s3.vld || en_s4;
	assign en_s2  = !item_s2.vld || en_s3;
	assign en_s1  = !item_s1.vld || en_s2;
	assign up_rdy = en_s1;

	assign ld_off_ok = 32'(up_item.lidx) < 32'(RANGE_DEPTH);
	assign ld_uni_ok = 32'(item_s2.lidx) < 32'(UNICODE_DEPTH);
	assign ld_cus_ok = 32'(item_s2.lidx) < 32'(CUSTOM_DEPTH);

	always_ff @(posedge clk) begin
		if (en_s1 && up_item.vld && up_item.mode == sjis_xl_pkg::MODE_LD_RANGE && ld_off_ok) begin
			off_mem[RW'(up_item.lidx)] <= up_item.loff;
		end
		if (en_s1) begin
			off_s1 <= off_mem[up_ent];
		end
	end

	// Index is formed without wrap; the search guarantees code >= bound on a hit.
	assign uidx   = {1'b0, item_s1.code} - {1'b0, srch_s1.bound} + {1'b0, off_s1};
	assign uni_ok = 32'(uidx) < 32'(UNICODE_DEPTH);
	assign cus_ok = 32'(item_s1.cidx) < 32'(CUSTOM_DEPTH);

	always_comb begin
		st_nx = sjis_xl_pkg::ST_NOTFOUND;
		if (item_s1.win) begin
			st_nx = cus_ok ? sjis_xl_pkg::ST_CUSTOM : sjis_xl_pkg::ST_OVERFLOW;
		end else if (srch_s1.found) begin
			st_nx = uni_ok ? sjis_xl_pkg::ST_RANGE : sjis_xl_pkg::ST_OVERFLOW;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && item_s2.vld && item_s2.mode == sjis_xl_pkg::MODE_LD_UNI && ld_uni_ok) begin
			uni_mem[UA'(item_s2.lidx)] <= item_s2.lval;
		end
		if (en_s3) begin
			uni_rd_s3 <= uni_mem[uaddr_s2];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && item_s2.vld && item_s2.mode == sjis_xl_pkg::MODE_LD_CUST && ld_cus_ok) begin
			cus_mem[CA'(item_s2.lidx)] <= item_s2.lval;
		end
		if (en_s3) begin
			cus_rd_s3 <= cus_mem[CA'(item_s2.cidx)];
		end
	end

	always_comb begin
		case (st_s3)
			sjis_xl_pkg::ST_RANGE:  char_nx = uni_rd_s3;
			sjis_xl_pkg::ST_CUSTOM: char_nx = cus_rd_s3;
			default:                char_nx = sjis_xl_pkg::NOT_FOUND_CHAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1  <= '0;
			srch_s1  <= '0;
			item_s2  <= '0;
			st_s2    <= sjis_xl_pkg::ST_NOTFOUND;
			uaddr_s2 <= '0;
			item_s3  <= '0;
			st_s3    <= sjis_xl_pkg::ST_NOTFOUND;
			vld_s4   <= 1'b0;
			st_s4    <= sjis_xl_pkg::ST_NOTFOUND;
			char_s4  <= '0;
		end else begin
			if (en_s1) begin
				item_s1 <= up_item;
				srch_s1 <= up_srch;
			end
			if (en_s2) begin
				item_s2  <= item_s1;
				st_s2    <= st_nx;
				uaddr_s2 <= UA'(uidx);
			end
			if (en_s3) begin
				item_s3 <= item_s2;
				st_s3   <= st_s2;
			end
			if (en_s4) begin
				// drop load items: they give no result
				vld_s4  <= item_s3.vld && item_s3.mode == sjis_xl_pkg::MODE_XLAT;
				st_s4   <= st_s3;
				char_s4 <= char_nx;
			end
		end
	end

	assign out_valid = vld_s4;
	assign char_out  = char_s4;
	assign status    = st_s4;

endmodule
`default_nettype wire
